[rtl/mqs_pkg.sv]
// ---------------------------------------------------------------------------
// mqs_pkg - shared types and constants for the message queue
// Request and response payloads, cell control, request and status codes.
// ---------------------------------------------------------------------------
package mqs_pkg;

    // default queue depth
    localparam int DEPTH_DEF = 16;
    // cells examined per search cycle
    localparam int SCAN_W = 8;

    // request codes
    localparam logic [2:0] REQ_PUSH      = 3'd0;
    localparam logic [2:0] REQ_POP       = 3'd1;
    localparam logic [2:0] REQ_REMOVE    = 3'd2;
    localparam logic [2:0] REQ_FIND_POS  = 3'd3;
    localparam logic [2:0] REQ_FIND_CODE = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] msg_handle;
        logic [31:0] msg_code;
        logic [3:0]  position;
    } mqs_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_handle;
        logic [31:0] out_code;
        logic [4:0]  entry_count;
        logic        is_empty;
    } mqs_rsp_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] code;
    } mqs_entry_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp;    // capture match flags
        logic load;   // write the incoming entry
        logic shift;  // take the neighbour's entry
    } mqs_cell_ctrl_t;

endpackage

[rtl/mqs_cell.sv]
// ---------------------------------------------------------------------------
// mqs_cell - one queue slot
// Holds one entry, compares it against the request keys and takes its
// neighbour's entry when a slot at or before it is deleted.
// ---------------------------------------------------------------------------
module mqs_cell (
    input  logic                    aclk,
    input  mqs_pkg::mqs_cell_ctrl_t ctrl,
    input  logic [15:0]             key_handle,
    input  logic [31:0]             key_code,
    input  mqs_pkg::mqs_entry_t     load_entry,
    input  mqs_pkg::mqs_entry_t     next_entry,
    output mqs_pkg::mqs_entry_t     entry,
    output logic                    hit_handle,
    output logic                    hit_code
);

    mqs_pkg::mqs_entry_t entry_reg;
    logic                hit_handle_reg;
    logic                hit_code_reg;

    // slot contents: load on push, shift down on delete
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            entry_reg <= load_entry;
        end else if (ctrl.shift) begin
            entry_reg <= next_entry;
        end
    end

    // match flags for the search that follows
    always_ff @(posedge aclk) begin
        if (ctrl.cmp) begin
            hit_handle_reg <= (entry_reg.handle == key_handle);
            hit_code_reg   <= (entry_reg.code == key_code);
        end
    end

    assign entry      = entry_reg;
    assign hit_handle = hit_handle_reg;
    assign hit_code   = hit_code_reg;

endmodule

[rtl/message_queue_with_search_unit.sv]
// ---------------------------------------------------------------------------
// message_queue_with_search_unit - ordered message queue with search
// Push, pop, remove by handle, find by position and find by code and rank
// over a row of slot cells; one response per request.
// ---------------------------------------------------------------------------
// Push, pop, find by position and unused codes: the result is registered in ACT
// once the output register is free; only then is the next request accepted.
// Remove and find by code: SCAN first ranks 8 slot match flags per cycle, chunk
// by chunk, until a match is found or the occupied slots are passed.
// The output register frees the input side once a result is waiting.
// Synchronous active-low reset empties the queue; slot contents are kept.
module message_queue_with_search_unit #(
    parameter int DEPTH = mqs_pkg::DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mqs_pkg::mqs_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mqs_pkg::mqs_rsp_t m_data
);

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int GW   = mqs_pkg::SCAN_W;
    localparam int SW   = $clog2(GW);
    localparam int NCH  = (DEPTH + GW - 1) / GW;
    localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PADW = (2 ** CHW) * GW;
    localparam int PW   = (CW > 4) ? CW : 4;
    localparam int OW   = (CW > 5) ? CW : 5;
    localparam int NBW  = CHW + SW + 1;
    localparam int BCW  = (NBW > CW) ? NBW : CW;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_ACT  = 2'd2;

    logic [1:0]          state_reg, state_next;
    mqs_pkg::mqs_req_t   req_reg;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                ok_reg, ok_next;
    logic [CHW-1:0]      chunk_reg, chunk_next;
    logic [4:0]          seen_reg, seen_next;
    logic [CW-1:0]       occ_reg, occ_next;
    logic                m_valid_reg;
    mqs_pkg::mqs_rsp_t   m_data_reg, rsp_next;

    logic                s_fire;
    logic                act_go;
    logic                push_ok;
    logic                del_ok;
    logic                read_ok;

    mqs_pkg::mqs_cell_ctrl_t ctrl [DEPTH];
    mqs_pkg::mqs_entry_t     entries [DEPTH];
    mqs_pkg::mqs_entry_t     load_entry;
    logic [DEPTH-1:0]        hit_h;
    logic [DEPTH-1:0]        hit_c;
    logic [PADW-1:0]         hit_pad;
    logic [PADW-1:0]         live_pad;
    logic [GW-1:0]           chunk_bits;
    logic                    scan_found;
    logic [SW-1:0]           scan_pos;
    logic [4:0]              scan_seen;
    logic [NBW-1:0]          next_base;
    logic                    scan_last;
    logic [OW-1:0]           occ_wide;

    assign s_fire  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign act_go  = (state_reg == S_ACT) && (!m_valid_reg || m_ready);

    assign push_ok = ok_reg && (req_reg.req_type == mqs_pkg::REQ_PUSH);
    assign del_ok  = ok_reg && (req_reg.req_type == mqs_pkg::REQ_POP ||
                                req_reg.req_type == mqs_pkg::REQ_REMOVE);
    assign read_ok = ok_reg && (req_reg.req_type == mqs_pkg::REQ_POP ||
                                req_reg.req_type == mqs_pkg::REQ_FIND_POS ||
                                req_reg.req_type == mqs_pkg::REQ_FIND_CODE);

    assign load_entry.handle = req_reg.msg_handle;
    assign load_entry.code   = req_reg.msg_code;

    // row of slot cells, slot 0 oldest
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        mqs_pkg::mqs_entry_t nbr;

        assign ctrl[k].cmp   = s_fire;
        assign ctrl[k].load  = act_go && push_ok && (idx_reg == IW'(k));
        assign ctrl[k].shift = act_go && del_ok && (IW'(k) >= idx_reg);

        if (k == DEPTH - 1) begin : g_last
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = entries[k + 1];
        end

        mqs_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl[k]),
            .key_handle (s_data.msg_handle),
            .key_code   (s_data.msg_code),
            .load_entry (load_entry),
            .next_entry (nbr),
            .entry      (entries[k]),
            .hit_handle (hit_h[k]),
            .hit_code   (hit_c[k])
        );
    end

    // occupied-slot mask and selected match flags, padded to whole chunks
    for (genvar k = 0; k < PADW; k++) begin : g_pad
        if (k < DEPTH) begin : g_in
            assign live_pad[k] = (CW'(k) < occ_reg);
            assign hit_pad[k]  = live_pad[k] &&
                ((req_reg.req_type == mqs_pkg::REQ_REMOVE) ? hit_h[k] : hit_c[k]);
        end else begin : g_out
            assign live_pad[k] = 1'b0;
            assign hit_pad[k]  = 1'b0;
        end
    end

    assign chunk_bits = hit_pad[chunk_reg * GW +: GW];

    // rank the matches of one chunk
    always_comb begin
        logic [4:0] s;
        s          = seen_reg;
        scan_found = 1'b0;
        scan_pos   = '0;
        for (int j = 0; j < GW; j++) begin
            if (chunk_bits[j] && !scan_found) begin
                if (req_reg.req_type == mqs_pkg::REQ_REMOVE ||
                    s == {1'b0, req_reg.position}) begin
                    scan_found = 1'b1;
                    scan_pos   = SW'(j);
                end
                s = (s == 5'd16) ? s : s + 5'd1;
            end
        end
        scan_seen = s;
    end

    // stop once the next chunk starts past the occupied slots
    assign next_base = NBW'({1'b0, chunk_reg} + (CHW + 1)'(1)) << SW;
    assign scan_last = (chunk_reg == CHW'(NCH - 1)) ||
                       (BCW'(next_base) >= BCW'(occ_reg));

    // sequencer
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ok_next    = ok_reg;
        chunk_next = chunk_reg;
        seen_next  = seen_reg;
        occ_next   = occ_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    chunk_next = '0;
                    seen_next  = '0;
                    state_next = S_ACT;
                    case (s_data.req_type)
                        mqs_pkg::REQ_PUSH: begin
                            idx_next = IW'(occ_reg);
                            ok_next  = (occ_reg < CW'(DEPTH));
                        end
                        mqs_pkg::REQ_POP: begin
                            idx_next = '0;
                            ok_next  = (occ_reg != '0);
                        end
                        mqs_pkg::REQ_FIND_POS: begin
                            idx_next = IW'(s_data.position);
                            ok_next  = (PW'(s_data.position) < PW'(occ_reg));
                        end
                        mqs_pkg::REQ_REMOVE, mqs_pkg::REQ_FIND_CODE: begin
                            ok_next    = 1'b0;
                            state_next = S_SCAN;
                        end
                        default: begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                seen_next = scan_seen;
                if (scan_found) begin
                    idx_next   = IW'({chunk_reg, scan_pos});
                    ok_next    = 1'b1;
                    state_next = S_ACT;
                end else if (scan_last) begin
                    ok_next    = 1'b0;
                    state_next = S_ACT;
                end else begin
                    chunk_next = chunk_reg + CHW'(1);
                end
            end
            S_ACT: begin
                if (act_go) begin
                    if (push_ok) begin
                        occ_next = occ_reg + CW'(1);
                    end else if (del_ok) begin
                        occ_next = occ_reg - CW'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // response assembly
    assign occ_wide = OW'(occ_next);
    always_comb begin
        rsp_next             = '0;
        rsp_next.entry_count = occ_wide[4:0];
        rsp_next.is_empty    = (occ_next == '0);
        if (req_reg.req_type == mqs_pkg::REQ_PUSH) begin
            rsp_next.status = ok_reg ? mqs_pkg::ST_OK : mqs_pkg::ST_FULL;
        end else begin
            rsp_next.status = ok_reg ? mqs_pkg::ST_OK : mqs_pkg::ST_MISS;
        end
        if (read_ok) begin
            rsp_next.out_handle = entries[idx_reg].handle;
            rsp_next.out_code   = entries[idx_reg].code;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (act_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and working registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= s_data;
        end
        idx_reg   <= idx_next;
        ok_reg    <= ok_next;
        chunk_reg <= chunk_next;
        seen_reg  <= seen_next;
        if (act_go) begin
            m_data_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
